// File: hdl/lcsr_pkg.sv
// Shared types and constants for the labeled CSR edge query block.
// Holds operation codes, config register indexes and the controller/datapath
// command and status structs. No dependencies.
package lcsr_pkg;

  localparam int OP_W    = 3;
  localparam int ADDR_W  = 12;
  localparam int WORD_W  = 16;
  localparam int VTX_W   = 10;
  localparam int LBL_W   = 4;
  localparam int VCNT_W  = 11;
  localparam int LCNT_W  = 5;
  localparam int DEG_W   = 12;
  localparam int TLBL_W  = 5;
  localparam int EA_W    = 18;   // effective image address, wide enough for base + id + k
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // bucket count is tied to the 5-bit target label and its no-bucket code
  localparam int MAX_LABELS = 16;

  localparam logic [OP_W-1:0] OP_LOAD_IMG  = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_LBL  = 3'd1;
  localparam logic [OP_W-1:0] OP_EDGE_TEST = 3'd2;
  localparam logic [OP_W-1:0] OP_LBL_DEG   = 3'd3;
  localparam logic [OP_W-1:0] OP_TOTAL_DEG = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_VTX_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LABEL_COUNT = 2'd1;

  localparam logic [TLBL_W-1:0] NO_BUCKET  = 5'd16;
  localparam logic [DEG_W-1:0]  DEGREE_MAX = 12'd4095;

  typedef enum logic [3:0] {
    A_SRC,     // src
    A_SRC1,    // src + 1
    A_PAIR,    // base + o
    A_PAIRM1,  // base + o - 1
    A_PAIRP1,  // base + o + 1
    A_VC,      // number of vertices
    A_NBR,     // base + img(vc) + k
    A_HI,      // base + bound - 1
    A_LO       // base + o - 1 (total degree)
  } addr_sel_t;

  typedef struct packed {
    addr_sel_t addr_sel;
    logic      accept;
    logic      wr_img;
    logic      wr_lbl;
    logic      ld_o;
    logic      zero_o;
    logic      o_inc2;
    logic      ld_bound;
    logic      ld_b;
    logic      zero_b;
    logic      ld_e;
    logic      ld_iv;
    logic      k_init;
    logic      k_inc;
    logic      lb_start;
    logic      lb_next;
    logic      lb_hit;
    logic      lb_miss;
    logic      set_found;
    logic      set_degree;
    logic      out_load;
  } lcsr_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic src_ok;
    logic src_zero;
    logic lb_more;
    logic lb_hit;
    logic o_ge_bound;
    logic pv_lt;
    logic pv_eq;
    logic o_zero;
    logic e_gt_b;
    logic k_lt_e;
    logic nbr_eq;
    logic eo_zero;
  } lcsr_status_t;

endpackage

// File: hdl/labeled_csr_edge_query.sv
// Top level of the labeled CSR edge query block.
// Joins lcsr_ctrl and lcsr_dp; depends on lcsr_pkg.
//
// Answers edge tests and out-degree queries on a labeled graph image in
// compressed sparse row form, held in an image RAM and a label bucket RAM that
// load words fill. Every word gives exactly one result word. Queries are paced
// by the single registered read port of the image RAM: a total out-degree
// reads the source's row entries and two label-pair ends, a label out-degree
// scans the label pairs of the source's segment, and an edge test first
// searches the buckets for the target's label, then scans the label pairs
// and compares the neighbours. A source out of range, a missing bucket or a
// missing label ends a query early. One word is worked at a time; the next word
// is taken in the cycle after the result enters the output register, which
// waits while a previous result is still held there.
module labeled_csr_edge_query #(
  parameter int IMAGE_WORDS = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lcsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcsr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [11:0] word_address, [27:12] word_value, [37:28] source_vertex,
  // [47:38] target_vertex, [51:48] edge_label, [55:52] zero
  input  logic [lcsr_pkg::IN_DATA_W-1:0]       in_tdata,
  // [2:0] operation
  input  logic [lcsr_pkg::OP_W-1:0]            in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] edge_found, [12:1] degree_count, [17:13] target_label, [23:18] zero
  output logic [lcsr_pkg::OUT_DATA_W-1:0]      out_tdata
);

  lcsr_pkg::lcsr_cmd_t    cmd;
  lcsr_pkg::lcsr_status_t st;

  assign cfg_ready = 1'b1;

  lcsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lcsr_dp #(
    .IMAGE_WORDS (IMAGE_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_data   (in_tdata),
    .in_op     (in_tuser),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_tdata)
  );

endmodule

// File: hdl/lcsr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lcsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lcsr_ctrl.sv
// Sequencer for the labeled CSR edge query block.
// Steps each item through its memory reads; depends on lcsr_pkg.
module lcsr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  lcsr_pkg::lcsr_status_t st,
  output lcsr_pkg::lcsr_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_LB, S_LB_CK,
    S_RG, S_RG1, S_RG2, S_SC, S_SC_CK, S_RB, S_RE, S_RX, S_NI, S_NK, S_NK_CK,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.addr_sel = lcsr_pkg::A_SRC;
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st.op)
          lcsr_pkg::OP_LOAD_IMG: begin
            cmd.wr_img = 1'b1;
            state_nxt = S_DONE;
          end
          lcsr_pkg::OP_LOAD_LBL: begin
            cmd.wr_lbl = 1'b1;
            state_nxt = S_DONE;
          end
          lcsr_pkg::OP_EDGE_TEST: begin
            cmd.lb_start = 1'b1;
            state_nxt = S_LB;
          end
          lcsr_pkg::OP_LBL_DEG:   state_nxt = S_RG;
          lcsr_pkg::OP_TOTAL_DEG: state_nxt = S_T0;
          default:                state_nxt = S_DONE;
        endcase
      end
      // target label search over buckets
      S_LB: begin
        if (st.lb_more) begin
          state_nxt = S_LB_CK;
        end else begin
          cmd.lb_miss = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_LB_CK: begin
        if (st.lb_hit) begin
          cmd.lb_hit = 1'b1;
          state_nxt = S_RG;
        end else begin
          cmd.lb_next = 1'b1;
          state_nxt = S_LB;
        end
      end
      // label range of the source
      S_RG: begin
        cmd.addr_sel = lcsr_pkg::A_SRC;
        state_nxt = st.src_ok ? S_RG1 : S_DONE;
      end
      S_RG1: begin
        cmd.ld_o   = !st.src_zero;
        cmd.zero_o = st.src_zero;
        cmd.addr_sel = lcsr_pkg::A_SRC1;
        state_nxt = S_RG2;
      end
      S_RG2: begin
        cmd.ld_bound = 1'b1;
        state_nxt = S_SC;
      end
      S_SC: begin
        cmd.addr_sel = lcsr_pkg::A_PAIR;
        state_nxt = st.o_ge_bound ? S_DONE : S_SC_CK;
      end
      S_SC_CK: begin
        cmd.addr_sel = lcsr_pkg::A_PAIRM1;
        if (st.pv_lt) begin
          cmd.o_inc2 = 1'b1;
          state_nxt = S_SC;
        end else if (st.pv_eq) begin
          state_nxt = S_RB;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RB: begin
        cmd.ld_b   = !st.o_zero;
        cmd.zero_b = st.o_zero;
        cmd.addr_sel = lcsr_pkg::A_PAIRP1;
        state_nxt = S_RE;
      end
      S_RE: begin
        cmd.ld_e = 1'b1;
        state_nxt = S_RX;
      end
      S_RX: begin
        cmd.addr_sel = lcsr_pkg::A_VC;
        if (!st.e_gt_b) begin
          state_nxt = S_DONE;
        end else if (st.op == lcsr_pkg::OP_LBL_DEG) begin
          cmd.set_degree = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_NI;
        end
      end
      S_NI: begin
        cmd.ld_iv  = 1'b1;
        cmd.k_init = 1'b1;
        state_nxt = S_NK;
      end
      // neighbour scan
      S_NK: begin
        cmd.addr_sel = lcsr_pkg::A_NBR;
        state_nxt = st.k_lt_e ? S_NK_CK : S_DONE;
      end
      S_NK_CK: begin
        if (st.nbr_eq) begin
          cmd.set_found = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_NK;
        end
      end
      // total out-degree
      S_T0: begin
        cmd.addr_sel = lcsr_pkg::A_SRC;
        state_nxt = st.src_ok ? S_T1 : S_DONE;
      end
      S_T1: begin
        cmd.ld_o   = !st.src_zero;
        cmd.zero_o = st.src_zero;
        cmd.addr_sel = lcsr_pkg::A_SRC1;
        state_nxt = S_T2;
      end
      S_T2: begin
        cmd.ld_bound = 1'b1;
        state_nxt = S_T3;
      end
      S_T3: begin
        cmd.addr_sel = lcsr_pkg::A_HI;
        state_nxt = st.eo_zero ? S_DONE : S_T4;
      end
      S_T4: begin
        cmd.ld_e = 1'b1;
        cmd.addr_sel = lcsr_pkg::A_LO;
        if (st.o_zero) begin
          cmd.zero_b = 1'b1;
          state_nxt = S_T6;
        end else begin
          state_nxt = S_T5;
        end
      end
      S_T5: begin
        cmd.ld_b = 1'b1;
        state_nxt = S_T6;
      end
      S_T6: begin
        cmd.set_degree = st.e_gt_b;
        state_nxt = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/lcsr_dp.sv
// Datapath for the labeled CSR edge query block: config registers, image and
// bucket memories, address generation, scan registers and the result word.
// Depends on lcsr_pkg and lcsr_ram.
module lcsr_dp #(
  parameter int IMAGE_WORDS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lcsr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lcsr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [lcsr_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [lcsr_pkg::OP_W-1:0]           in_op,
  input  lcsr_pkg::lcsr_cmd_t                 cmd,
  output lcsr_pkg::lcsr_status_t              st,
  output logic [lcsr_pkg::OUT_DATA_W-1:0]     out_data
);

  localparam int MAX_LABELS = lcsr_pkg::MAX_LABELS;
  localparam int IAW = $clog2(IMAGE_WORDS);
  localparam int LAW = $clog2(MAX_LABELS);
  localparam int LCW0 = $clog2(MAX_LABELS + 1);
  localparam int CW  = (LCW0 > lcsr_pkg::LCNT_W) ? LCW0 : lcsr_pkg::LCNT_W;
  localparam int EW  = lcsr_pkg::EA_W;
  localparam int WW  = lcsr_pkg::WORD_W;

  logic [lcsr_pkg::VCNT_W-1:0] vc_r;
  logic [lcsr_pkg::LCNT_W-1:0] lc_r;

  logic [lcsr_pkg::OP_W-1:0]   op_r;
  logic [lcsr_pkg::ADDR_W-1:0] addr_r;
  logic [WW-1:0]               val_r;
  logic [lcsr_pkg::VTX_W-1:0]  src_r, dst_r;
  logic [WW-1:0]               lab_r;
  logic [WW:0]                 o_r;
  logic [WW-1:0]               bound_r, b_r, e_r, iv_r, k_r, prev_r;
  logic [CW-1:0]               i_r;
  logic                        oob_r;
  logic                        found_r;
  logic [lcsr_pkg::DEG_W-1:0]  deg_r;
  logic [lcsr_pkg::TLBL_W-1:0] tl_r;
  logic                        out_found_r;
  logic [lcsr_pkg::DEG_W-1:0]  out_deg_r;
  logic [lcsr_pkg::TLBL_W-1:0] out_tl_r;

  logic [EW-1:0]  base, ea, wa;
  logic [WW-1:0]  img_rdata, bkt_rdata, imv, diff;
  logic [CW-1:0]  n_lbl;
  logic           img_we, bkt_we;

  assign base = EW'(vc_r) + EW'(1);
  assign wa   = EW'(addr_r);

  always_comb begin
    case (cmd.addr_sel)
      lcsr_pkg::A_SRC:    ea = EW'(src_r);
      lcsr_pkg::A_SRC1:   ea = EW'(src_r) + EW'(1);
      lcsr_pkg::A_PAIR:   ea = base + EW'(o_r);
      lcsr_pkg::A_PAIRM1: ea = base + EW'(o_r) - EW'(1);
      lcsr_pkg::A_PAIRP1: ea = base + EW'(o_r) + EW'(1);
      lcsr_pkg::A_VC:     ea = EW'(vc_r);
      lcsr_pkg::A_NBR:    ea = base + EW'(iv_r) + EW'(k_r);
      lcsr_pkg::A_HI:     ea = base + EW'(bound_r) - EW'(1);
      lcsr_pkg::A_LO:     ea = base + EW'(o_r) - EW'(1);
      default:            ea = '0;
    endcase
  end

  assign img_we = cmd.wr_img && (wa < EW'(IMAGE_WORDS));
  assign bkt_we = cmd.wr_lbl && (wa < EW'(MAX_LABELS));

  lcsr_ram #(.WIDTH(WW), .DEPTH(IMAGE_WORDS)) u_img (
    .clk   (clk),
    .we    (img_we),
    .waddr (wa[IAW-1:0]),
    .wdata (val_r),
    .raddr (ea[IAW-1:0]),
    .rdata (img_rdata)
  );

  lcsr_ram #(.WIDTH(WW), .DEPTH(MAX_LABELS)) u_bkt (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (wa[LAW-1:0]),
    .wdata (val_r),
    .raddr (i_r[LAW-1:0]),
    .rdata (bkt_rdata)
  );

  // reads past the image return zero
  assign imv   = oob_r ? '0 : img_rdata;
  assign n_lbl = (CW'(lc_r) > CW'(MAX_LABELS)) ? CW'(MAX_LABELS) : CW'(lc_r);
  assign diff  = e_r - b_r;

  always_comb begin
    st.op         = op_r;
    st.src_ok     = lcsr_pkg::VCNT_W'(src_r) < vc_r;
    st.src_zero   = (src_r == '0);
    st.lb_more    = i_r < n_lbl;
    st.lb_hit     = (WW'(dst_r) >= prev_r) && (WW'(dst_r) < bkt_rdata);
    st.o_ge_bound = o_r >= (WW+1)'(bound_r);
    st.pv_lt      = imv < lab_r;
    st.pv_eq      = imv == lab_r;
    st.o_zero     = (o_r == '0);
    st.e_gt_b     = e_r > b_r;
    st.k_lt_e     = k_r < e_r;
    st.nbr_eq     = imv == WW'(dst_r);
    st.eo_zero    = (bound_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
      lc_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        lcsr_pkg::CFG_VTX_COUNT:   vc_r <= cfg_wdata[lcsr_pkg::VCNT_W-1:0];
        lcsr_pkg::CFG_LABEL_COUNT: lc_r <= cfg_wdata[lcsr_pkg::LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    oob_r <= ea >= EW'(IMAGE_WORDS);
    if (cmd.accept) begin
      op_r    <= in_op;
      addr_r  <= in_data[11:0];
      val_r   <= in_data[27:12];
      src_r   <= in_data[37:28];
      dst_r   <= in_data[47:38];
      lab_r   <= WW'(in_data[51:48]);
      found_r <= 1'b0;
      deg_r   <= '0;
      tl_r    <= '0;
    end
    if (cmd.lb_start) begin
      i_r    <= '0;
      prev_r <= '0;
    end
    if (cmd.lb_next) begin
      i_r    <= i_r + CW'(1);
      prev_r <= bkt_rdata;
    end
    if (cmd.lb_hit) begin
      tl_r  <= lcsr_pkg::TLBL_W'(i_r);
      lab_r <= WW'(i_r);
    end
    if (cmd.lb_miss) begin
      tl_r <= lcsr_pkg::NO_BUCKET;
    end
    if (cmd.ld_o)     o_r <= (WW+1)'(imv);
    if (cmd.zero_o)   o_r <= '0;
    if (cmd.o_inc2)   o_r <= o_r + (WW+1)'(2);
    if (cmd.ld_bound) bound_r <= imv;
    if (cmd.ld_b)     b_r <= imv;
    if (cmd.zero_b)   b_r <= '0;
    if (cmd.ld_e)     e_r <= imv;
    if (cmd.ld_iv)    iv_r <= imv;
    if (cmd.k_init)   k_r <= b_r;
    if (cmd.k_inc)    k_r <= k_r + WW'(1);
    if (cmd.set_found) found_r <= 1'b1;
    if (cmd.set_degree) begin
      deg_r <= (diff > WW'(lcsr_pkg::DEGREE_MAX)) ? lcsr_pkg::DEGREE_MAX
                                                  : diff[lcsr_pkg::DEG_W-1:0];
    end
    if (cmd.out_load) begin
      out_found_r <= found_r;
      out_deg_r   <= deg_r;
      out_tl_r    <= tl_r;
    end
  end

  assign out_data = {6'd0, out_tl_r, out_deg_r, out_found_r};

endmodule

// File: sim/testbench.sv
// Self-checking testbench for labeled_csr_edge_query.
// Loads small CSR graph images, issues edge tests and degree queries under random
// idling and checks every result word against a local predictor; needs lcsr_pkg.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [lcsr_pkg::OP_W-1:0]   op;
    logic [lcsr_pkg::ADDR_W-1:0] addr;
    logic [lcsr_pkg::WORD_W-1:0] value;
    logic [lcsr_pkg::VTX_W-1:0]  src;
    logic [lcsr_pkg::VTX_W-1:0]  tgt;
    logic [lcsr_pkg::LBL_W-1:0]  lab;
  } query_word_t;

  // laid out as the result word: found in the lowest bit
  typedef struct packed {
    logic [lcsr_pkg::TLBL_W-1:0] tlabel;
    logic [lcsr_pkg::DEG_W-1:0]  degree;
    logic                        found;
  } answer_t;

  localparam int          IMG_DEPTH = 4096;
  localparam int          BKT_DEPTH = 16;
  localparam logic [lcsr_pkg::OP_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [lcsr_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lcsr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lcsr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [lcsr_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [lcsr_pkg::OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [lcsr_pkg::OUT_DATA_W-1:0] out_tdata;

  labeled_csr_edge_query i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [lcsr_pkg::WORD_W-1:0] graph_mem[IMG_DEPTH];
  bit                graph_wr[IMG_DEPTH];
  logic [lcsr_pkg::WORD_W-1:0] bucket_end[BKT_DEPTH];
  bit                bucket_wr[BKT_DEPTH];
  int unsigned       vertex_cnt = 0;
  int unsigned       label_cnt = 0;
  bit                touched_unwritten;

  query_word_t pending_words[$];
  answer_t     expected_answers[$];
  int          error_count = 0;
  int          results_seen = 0;
  int          edge_tests = 0;
  int          degree_queries = 0;
  bit          quiet = 1'b0;

  function automatic int unsigned image_read(int unsigned a);
    if (a >= IMG_DEPTH) return 0;
    if (!graph_wr[a]) touched_unwritten = 1'b1;
    return graph_mem[a];
  endfunction

  function automatic int unsigned bucket_read(int unsigned i);
    if (!bucket_wr[i]) touched_unwritten = 1'b1;
    return bucket_end[i];
  endfunction

  function automatic int unsigned bucket_of(int unsigned t);
    int unsigned n;
    int unsigned lo;
    n = (label_cnt < BKT_DEPTH) ? label_cnt : BKT_DEPTH;
    for (int unsigned i = 0; i < n; i++) begin
      lo = (i == 0) ? 0 : bucket_read(i - 1);
      if (t >= lo && t < bucket_read(i)) return i;
    end
    return lcsr_pkg::NO_BUCKET;
  endfunction

  // Neighbour index range [b, e) of vertex v under label lab.
  function automatic bit segment_range(int unsigned v, int unsigned lab,
                                       output int unsigned b, output int unsigned e);
    int unsigned base;
    int unsigned o;
    int unsigned bound;
    base = 1 + vertex_cnt;
    b = 0;
    e = 0;
    o = (v == 0) ? 0 : image_read(v);
    bound = image_read(v + 1);
    if (v >= vertex_cnt) return 1'b0;
    while (o < bound && image_read(base + o) < lab) o += 2;
    if (o >= bound || image_read(base + o) != lab) return 1'b0;
    b = (o == 0) ? 0 : image_read(base + o - 1);
    e = image_read(base + o + 1);
    return e > b;
  endfunction

  function automatic int unsigned clip_degree(int unsigned d);
    return (d > lcsr_pkg::DEGREE_MAX) ? lcsr_pkg::DEGREE_MAX : d;
  endfunction

  // Apply one word to the local image and work out its result word.
  function automatic answer_t csr_answer(query_word_t w);
    answer_t r;
    int unsigned b, e, ids, base, so, eo, hi, lo;
    r = '0;
    case (w.op)
      lcsr_pkg::OP_LOAD_IMG: begin
        graph_mem[w.addr] = w.value;
        graph_wr[w.addr] = 1'b1;
      end
      lcsr_pkg::OP_LOAD_LBL: begin
        if (w.addr < BKT_DEPTH) begin
          bucket_end[w.addr] = w.value;
          bucket_wr[w.addr] = 1'b1;
        end
      end
      lcsr_pkg::OP_EDGE_TEST: begin
        r.tlabel = lcsr_pkg::TLBL_W'(bucket_of(w.tgt));
        if (r.tlabel != lcsr_pkg::NO_BUCKET && segment_range(w.src, r.tlabel, b, e)) begin
          ids = 1 + vertex_cnt + image_read(vertex_cnt);
          for (int unsigned k = b; k < e; k++) begin
            if (image_read(ids + k) == w.tgt) begin
              r.found = 1'b1;
              break;
            end
          end
        end
      end
      lcsr_pkg::OP_LBL_DEG: begin
        if (segment_range(w.src, w.lab, b, e)) begin
          r.degree = lcsr_pkg::DEG_W'(clip_degree(e - b));
        end
      end
      lcsr_pkg::OP_TOTAL_DEG: begin
        if (w.src < vertex_cnt) begin
          base = 1 + vertex_cnt;
          so = (w.src == 0) ? 0 : image_read(w.src);
          eo = image_read(w.src + 1);
          if (eo != 0) begin
            hi = image_read(base + eo - 1);
            lo = (so != 0) ? image_read(base + so - 1) : 0;
            r.degree = (hi > lo) ? lcsr_pkg::DEG_W'(clip_degree(hi - lo)) : '0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic push_word(query_word_t w);
    touched_unwritten = 1'b0;
    expected_answers = {expected_answers, csr_answer(w)};
    pending_words = {pending_words, w};
    if (w.op == lcsr_pkg::OP_EDGE_TEST) edge_tests++;
    if (w.op == lcsr_pkg::OP_LBL_DEG || w.op == lcsr_pkg::OP_TOTAL_DEG) degree_queries++;
  endtask

  function automatic query_word_t make_word(logic [lcsr_pkg::OP_W-1:0] op,
                                            int unsigned addr, int unsigned value,
                                            int unsigned src, int unsigned tgt,
                                            int unsigned lab);
    query_word_t w;
    w.op = op;
    w.addr = lcsr_pkg::ADDR_W'(addr);
    w.value = lcsr_pkg::WORD_W'(value);
    w.src = lcsr_pkg::VTX_W'(src);
    w.tgt = lcsr_pkg::VTX_W'(tgt);
    w.lab = lcsr_pkg::LBL_W'(lab);
    return w;
  endfunction

  // Load word with the unused fields randomized.
  task automatic push_load(logic [lcsr_pkg::OP_W-1:0] op, int unsigned addr,
                           int unsigned value);
    push_word(make_word(op, addr, value, $urandom, $urandom, $urandom));
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [lcsr_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = lcsr_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == lcsr_pkg::CFG_VTX_COUNT) vertex_cnt = value & 32'h7FF;
    else label_cnt = value & 32'h1F;
  endtask

  // Build a CSR image over the first act_cnt of vcnt vertices, then query it.
  task automatic run_graph(int unsigned vcnt, int unsigned act_cnt, int unsigned lcnt,
                           int unsigned nq);
    int unsigned ends[BKT_DEPTH];
    int unsigned offs[$];
    int unsigned pair_lab[$];
    int unsigned pair_end[$];
    int unsigned nbrs[$];
    int unsigned span, cur, np, lab, cnt, lo, hi, t, base, last, used_end, pick, tries;
    query_word_t w;
    answer_t a;
    bit ok;
    wait_idle();
    write_reg(lcsr_pkg::CFG_VTX_COUNT, vcnt);
    write_reg(lcsr_pkg::CFG_LABEL_COUNT, lcnt);
    span = ((act_cnt > 0) ? act_cnt : 1) + 3;
    cur = 0;
    for (int i = 0; i < BKT_DEPTH; i++) begin
      cur += $urandom_range(0, span / 4 + 1);
      ends[i] = ($urandom_range(0, 15) == 0) ? $urandom_range(0, span) : cur;
      push_load(lcsr_pkg::OP_LOAD_LBL, i, ends[i]);
    end
    for (int unsigned v = 0; v < act_cnt; v++) begin
      np = $urandom_range(0, 3);
      lab = $urandom_range(0, 3);
      for (int unsigned p = 0; p < np && lab < 16; p++) begin
        cnt = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
        for (int unsigned k = 0; k < cnt; k++) begin
          lo = (lab == 0) ? 0 : ends[lab - 1];
          hi = ends[lab];
          if (lab < lcnt && hi > lo) t = $urandom_range(lo, hi - 1);
          else t = $urandom_range(0, act_cnt + 2);
          nbrs = {nbrs, t & 32'h3FF};
        end
        pair_lab = {pair_lab, lab};
        pair_end = {pair_end, nbrs.size()};
        lab += $urandom_range(1, 4);
      end
      offs = {offs, 2 * pair_lab.size()};
    end
    last = (act_cnt > 0) ? offs[act_cnt - 1] : 0;
    base = 1 + vcnt;
    push_load(lcsr_pkg::OP_LOAD_IMG, 0, vcnt);
    for (int unsigned v = 0; v < act_cnt; v++) push_load(lcsr_pkg::OP_LOAD_IMG, v + 1, offs[v]);
    push_load(lcsr_pkg::OP_LOAD_IMG, vcnt, last);
    if (act_cnt < vcnt || vcnt == 0) push_load(lcsr_pkg::OP_LOAD_IMG, act_cnt + 1, last);
    for (int unsigned p = 0; p < pair_lab.size(); p++) begin
      push_load(lcsr_pkg::OP_LOAD_IMG, base + 2 * p, pair_lab[p]);
      push_load(lcsr_pkg::OP_LOAD_IMG, base + 2 * p + 1, pair_end[p]);
    end
    for (int unsigned k = 0; k < nbrs.size(); k++) begin
      push_load(lcsr_pkg::OP_LOAD_IMG, base + last + k, nbrs[k]);
    end
    used_end = base + last + nbrs.size();

    for (int unsigned q = 0; q < nq; q++) begin
      pick = $urandom_range(0, 99);
      if (pick >= 85) begin
        // noise: spare image words, ignored bucket loads, unused codes
        case ($urandom_range(0, 2))
          0: push_load(lcsr_pkg::OP_LOAD_IMG, $urandom_range(used_end, IMG_DEPTH - 1),
                       $urandom);
          1: push_load(lcsr_pkg::OP_LOAD_LBL, $urandom_range(BKT_DEPTH, 4095), $urandom);
          default: push_word(make_word(lcsr_pkg::OP_W'($urandom_range(OP_SPARE5, OP_SPARE7)),
                                       $urandom, $urandom, $urandom, $urandom, $urandom));
        endcase
      end else begin
        ok = 1'b0;
        tries = 0;
        while (!ok && tries < 20) begin
          w.op = (pick < 40) ? lcsr_pkg::OP_EDGE_TEST :
                 (pick < 65) ? lcsr_pkg::OP_LBL_DEG : lcsr_pkg::OP_TOTAL_DEG;
          w.addr = lcsr_pkg::ADDR_W'($urandom);
          w.value = lcsr_pkg::WORD_W'($urandom);
          w.src = ($urandom_range(0, 99) < 85) ? lcsr_pkg::VTX_W'($urandom_range(0, act_cnt))
                                               : lcsr_pkg::VTX_W'($urandom);
          if (nbrs.size() > 0 && $urandom_range(0, 9) < 6)
            w.tgt = lcsr_pkg::VTX_W'(nbrs[$urandom_range(0, nbrs.size() - 1)]);
          else if ($urandom_range(0, 3) == 0) w.tgt = lcsr_pkg::VTX_W'($urandom);
          else w.tgt = lcsr_pkg::VTX_W'($urandom_range(0, act_cnt + 3));
          if (pair_lab.size() > 0 && $urandom_range(0, 9) < 6)
            w.lab = lcsr_pkg::LBL_W'(pair_lab[$urandom_range(0, pair_lab.size() - 1)]);
          else w.lab = lcsr_pkg::LBL_W'($urandom);
          // drop candidates that would read a word never loaded
          touched_unwritten = 1'b0;
          a = csr_answer(w);
          ok = !touched_unwritten;
          tries++;
        end
        if (ok) push_word(w);
        else push_word(make_word(OP_SPARE5, $urandom, $urandom, $urandom, $urandom, $urandom));
      end
    end
  endtask

  // Hand-built two-vertex image: self loop, missing bucket, missing label,
  // end below start, source out of range, degree saturation, unused codes.
  task automatic run_directed();
    int unsigned img_init[12] = '{2, 4, 6, 0, 1, 1, 3, 1, 2, 0, 2, 1};
    write_reg(lcsr_pkg::CFG_VTX_COUNT, 2);
    write_reg(lcsr_pkg::CFG_LABEL_COUNT, 2);
    push_load(lcsr_pkg::OP_LOAD_LBL, 0, 1);
    push_load(lcsr_pkg::OP_LOAD_LBL, 1, 3);
    for (int i = 0; i < 12; i++) push_load(lcsr_pkg::OP_LOAD_IMG, i, img_init[i]);
    push_word(make_word(lcsr_pkg::OP_EDGE_TEST, 0, 0, 0, 0, 0));
    push_word(make_word(lcsr_pkg::OP_EDGE_TEST, 0, 0, 0, 1, 0));
    push_word(make_word(lcsr_pkg::OP_EDGE_TEST, 0, 0, 0, 2, 0));
    push_word(make_word(lcsr_pkg::OP_EDGE_TEST, 0, 0, 0, 3, 0));
    push_word(make_word(lcsr_pkg::OP_EDGE_TEST, 0, 0, 1, 1, 0));
    push_word(make_word(lcsr_pkg::OP_TOTAL_DEG, 0, 0, 0, 0, 0));
    push_word(make_word(lcsr_pkg::OP_TOTAL_DEG, 0, 0, 1, 0, 0));
    push_word(make_word(lcsr_pkg::OP_LBL_DEG, 0, 0, 0, 0, 1));
    push_word(make_word(lcsr_pkg::OP_LBL_DEG, 0, 0, 0, 0, 5));
    push_word(make_word(lcsr_pkg::OP_LBL_DEG, 0, 0, 2, 0, 1));
    push_word(make_word(OP_SPARE5, 12'hFFF, 16'hFFFF, 10'h3FF, 10'h3FF, 4'hF));
    push_word(make_word(OP_SPARE7, 0, 0, 0, 0, 0));
    push_load(lcsr_pkg::OP_LOAD_LBL, 12'hFFF, 16'hFFFF);
    push_load(lcsr_pkg::OP_LOAD_IMG, 12'hFFF, 16'hFFFF);
    push_load(lcsr_pkg::OP_LOAD_IMG, 6, 5000);
    push_word(make_word(lcsr_pkg::OP_LBL_DEG, 0, 0, 0, 0, 1));
    push_word(make_word(lcsr_pkg::OP_TOTAL_DEG, 0, 0, 0, 0, 0));
  endtask

  // Sender: hold each word until taken, idle in bursts between words.
  bit in_fire = 1'b0;
  int send_gap = 0;
  always @(posedge clk) in_fire <= rst_n && in_tvalid && in_tready;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_fire) void'(pending_words.pop_front());
      if (!in_tvalid || in_fire) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 11);
          in_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_words[0].op;
          in_tdata <= {4'b0, pending_words[0].lab, pending_words[0].tgt, pending_words[0].src,
                       pending_words[0].value, pending_words[0].addr};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up.
  int  stall = 0;
  int  long_hold = 0;
  bit  long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold != 0) begin
      long_hold <= long_hold - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= 200) begin
      long_hold_done <= 1'b1;
      long_hold <= 400;
      out_tready <= 1'b0;
    end else if (stall != 0) begin
      stall <= stall - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    int      bad;
    bad = 0;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      got = answer_t'(out_tdata[17:0]);
      if (expected_answers.size() == 0) begin
        $display("%0t: result word expected none actual %h", $time, out_tdata);
        bad++;
      end else begin
        want = expected_answers.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: edge_found expected %0d actual %0d", $time, want.found, got.found);
          bad++;
        end
        if (got.degree !== want.degree) begin
          $display("%0t: degree_count expected %0d actual %0d", $time, want.degree,
                   got.degree);
          bad++;
        end
        if (got.tlabel !== want.tlabel) begin
          $display("%0t: target_label expected %0d actual %0d", $time, want.tlabel,
                   got.tlabel);
          bad++;
        end
      end
      error_count <= error_count + bad;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    run_graph(0, 0, 0, 40);
    run_graph(1, 1, 16, 80);
    run_graph(6, 6, 3, 150);
    run_graph(16, 16, 16, 180);
    run_graph(40, 30, 8, 180);
    run_graph(1024, 12, 16, 150);
    wait_idle();
    quiet = 1'b1;
    run_graph(20, 20, 5, 190);
    wait_idle();
    repeat (50) @(posedge clk);
    if (expected_answers.size() != 0) error_count = error_count + 1;
    $display("Covered %0d result words: %0d edge tests, %0d degree queries,",
             results_seen, edge_tests, degree_queries);
    $display("vertex counts 0 to 1024 and label counts 0 to 16, with stalls on both sides.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
